FILE: rtl/dive_pkg.sv
// dive_pkg: shared types and constants for the divisor enumerator.
// No dependencies; used by every rtl/ file of the block except dive_div.
package dive_pkg;

   // Fixed width of the number and divisor ports.
   localparam int NUMBER_WIDTH = 13;

   // Depth of the queue between front and back (power of two).
   localparam int QUEUE_DEPTH = 2;

   // Back-end sequencer states.
   typedef enum logic [2:0] {
      ENG_IDLE,
      ENG_ASC,
      ENG_ASC_DIV,
      ENG_DESC,
      ENG_DESC_DIV,
      ENG_EMIT
   } eng_state_type;

   // Queue head status as seen by the back end.
   typedef struct packed {
      logic valid;
      logic is_zero;
   } queue_status_type;

endpackage

FILE: rtl/dive_div.sv
// dive_div: restoring divider, one quotient bit per cycle.
// Depends on nothing; used by dive_engine.
module dive_div #(
   parameter int NUM_BITS = 13,
   parameter int DEN_BITS = 7
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [NUM_BITS-1:0] dividend,
   input  logic [DEN_BITS-1:0] divisor,
   output logic                done,
   output logic [NUM_BITS-1:0] quotient,
   output logic [DEN_BITS-1:0] remainder
);

   localparam int CNT_BITS = $clog2(NUM_BITS + 1);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [NUM_BITS-1:0] quo_ff, quo_in;
   logic [DEN_BITS-1:0] rem_ff, rem_in;
   logic [DEN_BITS-1:0] den_ff, den_in;

   logic [DEN_BITS:0]   trial;
   logic [DEN_BITS:0]   diff;
   logic                fits;

   assign trial = {rem_ff, quo_ff[NUM_BITS-1]};
   assign fits  = trial >= {1'b0, den_ff};
   assign diff  = trial - {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = dividend;
         rem_in  = '0;
         den_in  = divisor;
      end else if (busy_ff) begin
         rem_in = fits ? diff[DEN_BITS-1:0] : trial[DEN_BITS-1:0];
         quo_in = {quo_ff[NUM_BITS-2:0], fits};
         cnt_in = cnt_ff + CNT_BITS'(1);
         if (cnt_ff == CNT_BITS'(NUM_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

FILE: rtl/dive_front.sv
// dive_front: accepts request items, masks and classifies them, queues them.
// Depends on dive_pkg.
module dive_front #(
   parameter int NUMBER_BITS = 13
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [dive_pkg::NUMBER_WIDTH-1:0]  req_number,
   output dive_pkg::queue_status_type         q_status,
   output logic [NUMBER_BITS-1:0]             q_number,
   input  logic                               q_pop
);

   localparam int PTR_BITS = (dive_pkg::QUEUE_DEPTH > 1) ? $clog2(dive_pkg::QUEUE_DEPTH) : 1;
   localparam int CNT_BITS = $clog2(dive_pkg::QUEUE_DEPTH + 1);

   logic [NUMBER_BITS-1:0] num_mem [dive_pkg::QUEUE_DEPTH];
   logic                   zero_mem [dive_pkg::QUEUE_DEPTH];

   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;

   logic [NUMBER_BITS-1:0] masked;
   logic                   push;

   // upper bits beyond NUMBER_BITS are dropped here
   assign masked    = req_number[NUMBER_BITS-1:0];
   assign req_stall = cnt_ff == CNT_BITS'(dive_pkg::QUEUE_DEPTH);
   assign push      = req_valid && !req_stall;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + PTR_BITS'(1);
      end
      if (q_pop) begin
         rd_ptr_in = rd_ptr_ff + PTR_BITS'(1);
      end
      if (push && !q_pop) begin
         cnt_in = cnt_ff + CNT_BITS'(1);
      end else if (!push && q_pop) begin
         cnt_in = cnt_ff - CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         num_mem[wr_ptr_ff]  <= masked;
         zero_mem[wr_ptr_ff] <= masked == '0;
      end
   end

   assign q_status.valid   = cnt_ff != '0;
   assign q_status.is_zero = zero_mem[rd_ptr_ff];
   assign q_number         = num_mem[rd_ptr_ff];

endmodule

FILE: rtl/dive_engine.sv
// dive_engine: trial-division sequencer with output register.
// Depends on dive_pkg and dive_div.
module dive_engine #(
   parameter int NUMBER_BITS = 13
) (
   input  logic                              clock,
   input  logic                              reset,
   input  dive_pkg::queue_status_type        q_status,
   input  logic [NUMBER_BITS-1:0]            q_number,
   output logic                              q_pop,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [dive_pkg::NUMBER_WIDTH-1:0] rsp_divisor,
   output logic                              rsp_is_last,
   output logic                              rsp_no_divisors
);

   // candidates never exceed ceil(sqrt(2^NUMBER_BITS - 1))
   localparam int CAND_BITS = NUMBER_BITS / 2 + 1;
   localparam int SQ_BITS   = 2 * CAND_BITS;

   dive_pkg::eng_state_type state_ff, state_in;
   dive_pkg::eng_state_type ret_ff, ret_in;

   logic [NUMBER_BITS-1:0] n_ff, n_in;
   logic [CAND_BITS-1:0]   cand_ff, cand_in;
   logic [NUMBER_BITS-1:0] pend_ff, pend_in;

   logic                              out_valid_ff, out_valid_in;
   logic [dive_pkg::NUMBER_WIDTH-1:0] out_div_ff, out_div_in;
   logic                              out_last_ff, out_last_in;
   logic                              out_none_ff, out_none_in;

   logic [SQ_BITS-1:0]     sq;
   logic [SQ_BITS-1:0]     n_ext;
   logic                   div_start;
   logic                   div_done;
   logic [NUMBER_BITS-1:0] div_quo;
   logic [CAND_BITS-1:0]   div_rem;
   logic                   out_free;

   assign sq       = SQ_BITS'(cand_ff) * SQ_BITS'(cand_ff);
   assign n_ext    = SQ_BITS'(n_ff);
   assign out_free = !out_valid_ff || !rsp_stall;

   dive_div #(
      .NUM_BITS (NUMBER_BITS),
      .DEN_BITS (CAND_BITS)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (n_ff),
      .divisor   (cand_ff),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   always_comb begin
      state_in     = state_ff;
      ret_in       = ret_ff;
      n_in         = n_ff;
      cand_in      = cand_ff;
      pend_in      = pend_ff;
      q_pop        = 1'b0;
      div_start    = 1'b0;
      out_valid_in = out_valid_ff && rsp_stall;
      out_div_in   = out_div_ff;
      out_last_in  = out_last_ff;
      out_none_in  = out_none_ff;

      unique case (state_ff)
         dive_pkg::ENG_IDLE: begin
            if (q_status.valid) begin
               q_pop = 1'b1;
               n_in  = q_number;
               if (q_status.is_zero) begin
                  pend_in  = '0;
                  ret_in   = dive_pkg::ENG_IDLE;
                  state_in = dive_pkg::ENG_EMIT;
               end else begin
                  cand_in  = CAND_BITS'(1);
                  state_in = dive_pkg::ENG_ASC;
               end
            end
         end
         dive_pkg::ENG_ASC: begin
            priority if (sq < n_ext) begin
               div_start = 1'b1;
               state_in  = dive_pkg::ENG_ASC_DIV;
            end else if (sq == n_ext) begin
               // exact square root, emitted once
               pend_in  = NUMBER_BITS'(cand_ff);
               cand_in  = cand_ff - CAND_BITS'(1);
               ret_in   = dive_pkg::ENG_DESC;
               state_in = dive_pkg::ENG_EMIT;
            end else begin
               cand_in  = cand_ff - CAND_BITS'(1);
               state_in = dive_pkg::ENG_DESC;
            end
         end
         dive_pkg::ENG_ASC_DIV: begin
            if (div_done) begin
               cand_in = cand_ff + CAND_BITS'(1);
               if (div_rem == '0) begin
                  pend_in  = NUMBER_BITS'(cand_ff);
                  ret_in   = dive_pkg::ENG_ASC;
                  state_in = dive_pkg::ENG_EMIT;
               end else begin
                  state_in = dive_pkg::ENG_ASC;
               end
            end
         end
         dive_pkg::ENG_DESC: begin
            if (cand_ff == '0) begin
               state_in = dive_pkg::ENG_IDLE;
            end else begin
               div_start = 1'b1;
               state_in  = dive_pkg::ENG_DESC_DIV;
            end
         end
         dive_pkg::ENG_DESC_DIV: begin
            if (div_done) begin
               cand_in = cand_ff - CAND_BITS'(1);
               if (div_rem == '0) begin
                  pend_in  = div_quo;
                  ret_in   = dive_pkg::ENG_DESC;
                  state_in = dive_pkg::ENG_EMIT;
               end else begin
                  state_in = dive_pkg::ENG_DESC;
               end
            end
         end
         dive_pkg::ENG_EMIT: begin
            if (out_free) begin
               // the number itself is always the final divisor; zero gives 0 == 0
               out_valid_in = 1'b1;
               out_div_in   = dive_pkg::NUMBER_WIDTH'(pend_ff);
               out_last_in  = pend_ff == n_ff;
               out_none_in  = n_ff == '0;
               state_in     = ret_ff;
            end
         end
         default: begin
            state_in = dive_pkg::ENG_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dive_pkg::ENG_IDLE;
         ret_ff       <= dive_pkg::ENG_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ret_ff       <= ret_in;
         out_valid_ff <= out_valid_in;
      end
      n_ff        <= n_in;
      cand_ff     <= cand_in;
      pend_ff     <= pend_in;
      out_div_ff  <= out_div_in;
      out_last_ff <= out_last_in;
      out_none_ff <= out_none_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_divisor     = out_div_ff;
   assign rsp_is_last     = out_last_ff;
   assign rsp_no_divisors = out_none_ff;

endmodule

FILE: rtl/divisor_enumerator.sv
// divisor_enumerator: lists all divisors of a number in ascending order.
// Depends on dive_pkg, dive_front, dive_engine (and dive_div below it).
//
//   channel | ports                                          | dir | meaning
//   --------+------------------------------------------------+-----+--------------------------
//   req     | req_valid, req_stall, req_number[12:0]         | in  | one number per item
//   rsp     | rsp_valid, rsp_stall, rsp_divisor[12:0],       | out | one divisor per item,
//           | rsp_is_last, rsp_no_divisors                   |     | last one flagged
//
// Trials: each trial division runs in the shared bit-serial divider; a
//   nonzero number n costs 2*(ceil(sqrt(n)) - 1) trials plus one emit step
//   per emitted divisor, which waits while the output register is stalled.
//   A zero input gives its single empty item with no trials.
// Reset: synchronous, active high; clears the queue, the sequencer and rsp_valid.
// Stalls: a two-entry queue lets req keep flowing while the back end works;
//   rsp_stall only holds the output register and freezes the sequencer at emit.
module divisor_enumerator #(
   parameter int NUMBER_BITS = 13
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [dive_pkg::NUMBER_WIDTH-1:0] req_number,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [dive_pkg::NUMBER_WIDTH-1:0] rsp_divisor,
   output logic                              rsp_is_last,
   output logic                              rsp_no_divisors
);

   // queue head seen by the back end
   dive_pkg::queue_status_type q_status;
   logic [NUMBER_BITS-1:0]     q_number;
   logic                       q_pop;

   // front: masks to NUMBER_BITS, flags zero, queues the item
   dive_front #(
      .NUMBER_BITS (NUMBER_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_number (req_number),
      .q_status   (q_status),
      .q_number   (q_number),
      .q_pop      (q_pop)
   );

   // back: ascending trials, square root, descending cofactors
   dive_engine #(
      .NUMBER_BITS (NUMBER_BITS)
   ) u_engine (
      .clock           (clock),
      .reset           (reset),
      .q_status        (q_status),
      .q_number        (q_number),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_divisor     (rsp_divisor),
      .rsp_is_last     (rsp_is_last),
      .rsp_no_divisors (rsp_no_divisors)
   );

endmodule

FILE: rtl/dive_checker.sv
// dive_checker: port-level checks on divisor_enumerator, bound to the top.
// Depends on dive_pkg.
module dive_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_stall,
   input logic [dive_pkg::NUMBER_WIDTH-1:0] req_number,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input logic [dive_pkg::NUMBER_WIDTH-1:0] rsp_divisor,
   input logic                              rsp_is_last,
   input logic                              rsp_no_divisors
);

   // stalled result item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_divisor)
         && $stable(rsp_is_last) && $stable(rsp_no_divisors))
      else $error("stalled rsp item changed");

   // stalled request item holds
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_number))
      else $error("stalled req item changed");

   // empty item is alone and carries divisor 0
   a_empty_item: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_no_divisors |-> rsp_is_last && rsp_divisor == '0)
      else $error("empty item malformed");

   // a real divisor is never zero
   a_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_no_divisors |-> rsp_divisor != '0)
      else $error("zero divisor emitted");

   // reset empties queue and output
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("state not cleared by reset");

endmodule

bind divisor_enumerator dive_checker u_dive_checker (.*);
